[rtl/core/rqlm_pkg.sv]
// shared types, constants and a helper function for the run-queue latency monitor
`default_nettype none

package rqlm_pkg;

   // fixed field widths
   localparam int unsigned TIME_W     = 64;
   localparam int unsigned US_W       = 55;
   localparam int unsigned BUCKET_W   = 6;
   localparam int unsigned TASK_W     = 10;
   localparam int unsigned GROUP_W    = 8;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned HIST_DEPTH = 64;

   // nanoseconds per microsecond, taken by reciprocal multiplication:
   // floor(x / 1000) = ((x >> 3) * RECIP_1000) >> 68, exact over 64 bits
   localparam int unsigned US_DIVISOR       = 1000;
   localparam logic [63:0] RECIP_1000       = 64'h20C4_9BA5_E353_F7CF;
   localparam int unsigned RECIP_PRE_SHIFT  = 3;
   localparam int unsigned RECIP_POST_SHIFT = 68;
   localparam int unsigned MUL_A_W          = TIME_W - RECIP_PRE_SHIFT;
   localparam int unsigned MUL_ACC_W        = 128;
   localparam int unsigned MUL_STEPS        = 4;
   localparam int unsigned MUL_CNT_W        = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_TRACK_FLOOR    = 1'b1;

   // reset values of the configuration registers
   localparam logic [TIME_W-1:0] SLOW_THRESHOLD_RST = 64'd5000;
   localparam logic [TIME_W-1:0] TRACK_FLOOR_RST    = 64'd100;

   typedef enum logic {
      FUNC_WAKEUP = 1'b0,
      FUNC_SWITCH = 1'b1
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [TASK_W-1:0]   task_id;
      logic [GROUP_W-1:0]  group_id;
      logic [TIME_W-1:0]   timestamp_ns;
   } item_type;

   typedef struct packed {
      logic                 matched;
      logic [TIME_W-1:0]    wait_ns;
      logic [US_W-1:0]      wait_us;
      logic [BUCKET_W-1:0]  bucket;
      logic [TIME_W-1:0]    bucket_count;
      logic                 tracked;
      logic                 slow;
      logic [TIME_W-1:0]    grp_switches;
      logic [TIME_W-1:0]    grp_total_ns;
      logic [TIME_W-1:0]    grp_max_ns;
      logic [TIME_W-1:0]    grp_slow_count;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] switches;
      logic [TIME_W-1:0] total_ns;
      logic [TIME_W-1:0] max_ns;
      logic [TIME_W-1:0] slow_count;
      logic [TIME_W-1:0] last_seen;
   } grp_entry_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_DIV,
      S_BKT,
      S_RD,
      S_UPD
   } state_type;

   // floor(log2(v)) of a non-zero value; the result never exceeds 55
   function automatic logic [BUCKET_W-1:0] floor_log2(input logic [US_W:0] v);
      logic [BUCKET_W-1:0] r;
      r = '0;
      for (int i = 0; i <= int'(US_W); i++) begin
         if (v[i]) begin
            r = BUCKET_W'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/rqlm_front.sv]
// front end: takes transactions and holds them in a two-entry queue
`default_nettype none

module rqlm_front
   import rqlm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire item_type item_i,
   input  wire logic     clearing_i,
   input  wire logic     pop_i,
   output      head_type head_o,
   output      logic     busy
);

   localparam int unsigned QDEPTH = 2;

   item_type    q_ff [QDEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        full;

   // accept while there is room and the task store is not being cleared
   assign full = (count_ff == 2'(QDEPTH));
   assign busy = full || clearing_i;
   assign push = start && !busy;

   assign head_o.valid = (count_ff != 2'd0);
   assign head_o.item  = q_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_i ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop_i) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop_i) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_i;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> count_ff != 2'd0)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QDEPTH))
      else $error("queue overfilled");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop_i |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count missed a push");

endmodule

`default_nettype wire

[rtl/core/rqlm_div1000.sv]
// divide by 1000 through reciprocal multiplication, one 32x32 partial product per cycle
`default_nettype none

module rqlm_div1000
   import rqlm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start_i,
   input  wire logic [TIME_W-1:0] dividend_i,
   output      logic              done_o,
   output      logic [US_W-1:0]   quot_o
);

   logic                  busy_ff, busy_in;
   logic [MUL_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MUL_A_W-1:0]    a_ff, a_in;
   logic [MUL_ACC_W-1:0]  acc_ff, acc_in;
   logic                  done_ff, done_in;
   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic [63:0]           prod;
   logic [MUL_ACC_W-1:0]  addend;

   // pick the partial product of this step
   always_comb begin
      case (cnt_ff)
         2'd0: begin
            mul_a = a_ff[31:0];
            mul_b = RECIP_1000[31:0];
         end
         2'd1: begin
            mul_a = a_ff[31:0];
            mul_b = RECIP_1000[63:32];
         end
         2'd2: begin
            mul_a = 32'(a_ff[MUL_A_W-1:32]);
            mul_b = RECIP_1000[31:0];
         end
         default: begin
            mul_a = 32'(a_ff[MUL_A_W-1:32]);
            mul_b = RECIP_1000[63:32];
         end
      endcase
      prod = 64'(mul_a) * 64'(mul_b);
      case (cnt_ff)
         2'd0:    addend = {64'd0, prod};
         2'd1:    addend = {32'd0, prod, 32'd0};
         2'd2:    addend = {32'd0, prod, 32'd0};
         default: addend = {prod, 64'd0};
      endcase
   end

   // step sequencing and accumulation
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (start_i) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = dividend_i[TIME_W-1:RECIP_PRE_SHIFT];
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + addend;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign done_o = done_ff;
   assign quot_o = acc_ff[RECIP_POST_SHIFT +: US_W];

endmodule

`default_nettype wire

[rtl/core/rqlm_back.sv]
// back end: wake-time store, histogram, group statistics and sequencer
`default_nettype none

module rqlm_back
   import rqlm_pkg::*;
#(
   parameter int unsigned TASK_SLOTS  = 1024,
   parameter int unsigned GROUP_SLOTS = 256
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire head_type          head_i,
   input  wire logic [TIME_W-1:0] slow_threshold_i,
   input  wire logic [TIME_W-1:0] track_floor_i,
   output      logic              pop_o,
   output      logic              clearing_o,
   output      logic              rsp_valid_o,
   output      rsp_type           rsp_o
);

   localparam int unsigned TIDX_W = $clog2(TASK_SLOTS);
   localparam int unsigned GIDX_W = $clog2(GROUP_SLOTS);
   localparam int unsigned HIDX_W = $clog2(HIST_DEPTH);

   // index reduction by a constant through shifted compare and subtract
   function automatic logic [TIDX_W-1:0] task_index(input logic [TASK_W-1:0] v);
      logic [31:0] r;
      r = 32'(v);
      for (int k = int'(TASK_W) - 1; k >= 0; k--) begin
         if (r >= (32'(TASK_SLOTS) << k)) begin
            r = r - (32'(TASK_SLOTS) << k);
         end
      end
      return r[TIDX_W-1:0];
   endfunction

   function automatic logic [GIDX_W-1:0] group_index(input logic [GROUP_W-1:0] v);
      logic [31:0] r;
      r = 32'(v);
      for (int k = int'(GROUP_W) - 1; k >= 0; k--) begin
         if (r >= (32'(GROUP_SLOTS) << k)) begin
            r = r - (32'(GROUP_SLOTS) << k);
         end
      end
      return r[GIDX_W-1:0];
   endfunction

   // memories: task entries hold {valid, wake time}
   logic [TIME_W:0]     task_mem [TASK_SLOTS];
   logic [TIME_W-1:0]   hist_mem [HIST_DEPTH];
   grp_entry_type       grp_mem  [GROUP_SLOTS];

   logic [TIME_W:0]     task_rd_ff;
   logic [TIME_W-1:0]   hist_rd_ff;
   grp_entry_type       grp_rd_ff;

   logic [HIST_DEPTH-1:0]  hist_vld_ff, hist_vld_in;
   logic [GROUP_SLOTS-1:0] grp_vld_ff, grp_vld_in;

   state_type           state_ff, state_in;
   logic [TIDX_W-1:0]   clr_ff, clr_in;
   item_type            item_ff, item_in;
   logic [TIME_W-1:0]   wait_ns_ff, wait_ns_in;
   logic [US_W-1:0]     us_ff, us_in;
   logic [BUCKET_W-1:0] bucket_ff, bucket_in;
   logic                slow_ff, slow_in;
   logic                trk_ff, trk_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                task_we;
   logic [TIDX_W-1:0]   task_waddr;
   logic [TIME_W:0]     task_wdata;
   logic                hist_we;
   logic [TIME_W-1:0]   hist_new;
   logic                grp_we;
   grp_entry_type       grp_old;
   grp_entry_type       grp_new;
   logic                div_start;
   logic                div_done;
   logic [US_W-1:0]     div_quot;
   logic [TIME_W-1:0]   wait_calc;
   logic [TIDX_W-1:0]   head_tidx;
   logic [TIDX_W-1:0]   item_tidx;
   logic [GIDX_W-1:0]   item_gidx;
   logic [HIDX_W-1:0]   hidx;

   assign head_tidx  = task_index(head_i.item.task_id);
   assign item_tidx  = task_index(item_ff.task_id);
   assign item_gidx  = group_index(item_ff.group_id);
   assign hidx       = HIDX_W'(bucket_ff);
   assign wait_calc  = item_ff.timestamp_ns - task_rd_ff[TIME_W-1:0];

   rqlm_div1000 u_div (
      .clock      (clock),
      .reset      (reset),
      .start_i    (div_start),
      .dividend_i (wait_calc),
      .done_o     (div_done),
      .quot_o     (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == TIDX_W'(TASK_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head_i.valid && head_i.item.func == FUNC_SWITCH) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = task_rd_ff[TIME_W] ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_BKT;
            end
         end
         S_BKT:   state_in = S_RD;
         S_RD:    state_in = S_UPD;
         S_UPD:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // group update for a tracked switch and histogram count for a matched one
   always_comb begin
      grp_old = grp_vld_ff[item_gidx] ? grp_rd_ff : '0;
      grp_new.switches   = grp_old.switches + 1'b1;
      grp_new.total_ns   = grp_old.total_ns + wait_ns_ff;
      grp_new.slow_count = grp_old.slow_count + TIME_W'(slow_ff);
      grp_new.max_ns     = (wait_ns_ff > grp_old.max_ns) ? wait_ns_ff : grp_old.max_ns;
      grp_new.last_seen  = item_ff.timestamp_ns;
      hist_new = (hist_vld_ff[hidx] ? hist_rd_ff : '0) + 1'b1;
   end

   // outputs of each state
   always_comb begin
      pop_o        = 1'b0;
      task_we      = 1'b0;
      task_waddr   = head_tidx;
      task_wdata   = {1'b1, head_i.item.timestamp_ns};
      hist_we      = 1'b0;
      grp_we       = 1'b0;
      div_start    = 1'b0;
      clr_in       = clr_ff;
      item_in      = item_ff;
      wait_ns_in   = wait_ns_ff;
      us_in        = us_ff;
      bucket_in    = bucket_ff;
      slow_in      = slow_ff;
      trk_in       = trk_ff;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      hist_vld_in  = hist_vld_ff;
      grp_vld_in   = grp_vld_ff;
      case (state_ff)
         S_CLEAR: begin
            task_we    = 1'b1;
            task_waddr = clr_ff;
            task_wdata = '0;
            clr_in     = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (head_i.valid) begin
               pop_o   = 1'b1;
               item_in = head_i.item;
               // a wakeup stores its time and answers with zeros
               if (head_i.item.func == FUNC_WAKEUP) begin
                  task_we      = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_LOOK: begin
            if (task_rd_ff[TIME_W]) begin
               task_we    = 1'b1;
               task_waddr = item_tidx;
               task_wdata = {1'b0, task_rd_ff[TIME_W-1:0]};
               wait_ns_in = wait_calc;
               div_start  = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         S_DIV: begin
            us_in = div_quot;
         end
         S_BKT: begin
            bucket_in = floor_log2({1'b0, us_ff} + (US_W+1)'(1));
            slow_in   = TIME_W'(us_ff) >= slow_threshold_i;
            trk_in    = TIME_W'(us_ff) >= track_floor_i;
         end
         S_RD: begin
         end
         S_UPD: begin
            hist_we            = 1'b1;
            hist_vld_in[hidx]  = 1'b1;
            rsp_valid_in       = 1'b1;
            rsp_in.matched     = 1'b1;
            rsp_in.wait_ns     = wait_ns_ff;
            rsp_in.wait_us     = us_ff;
            rsp_in.bucket      = bucket_ff;
            rsp_in.bucket_count = hist_new;
            rsp_in.slow        = slow_ff;
            if (trk_ff) begin
               grp_we                = 1'b1;
               grp_vld_in[item_gidx] = 1'b1;
               rsp_in.tracked        = 1'b1;
               rsp_in.grp_switches   = grp_new.switches;
               rsp_in.grp_total_ns   = grp_new.total_ns;
               rsp_in.grp_max_ns     = grp_new.max_ns;
               rsp_in.grp_slow_count = grp_new.slow_count;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hist_vld_ff  <= '0;
         grp_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_vld_ff  <= hist_vld_in;
         grp_vld_ff   <= grp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      wait_ns_ff <= wait_ns_in;
      us_ff      <= us_in;
      bucket_ff  <= bucket_in;
      slow_ff    <= slow_in;
      trk_ff     <= trk_in;
      rsp_ff     <= rsp_in;
   end

   // task store
   always_ff @(posedge clock) begin
      if (task_we) begin
         task_mem[task_waddr] <= task_wdata;
      end
      task_rd_ff <= task_mem[head_tidx];
   end

   // histogram store
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hidx] <= hist_new;
      end
      hist_rd_ff <= hist_mem[hidx];
   end

   // group store
   always_ff @(posedge clock) begin
      if (grp_we) begin
         grp_mem[item_gidx] <= grp_new;
      end
      grp_rd_ff <= grp_mem[item_gidx];
   end

   assign clearing_o  = (state_ff == S_CLEAR);
   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_o       = rsp_ff;

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff)
      else $error("transaction answered during clearing pass");

   a_tracked_matched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.tracked |-> rsp_ff.matched)
      else $error("group update without a match");

   a_pop_idle_only: assert property (@(posedge clock) disable iff (reset)
      pop_o |-> state_ff == S_IDLE)
      else $error("queue popped while an item is in flight");

endmodule

`default_nettype wire

[rtl/core/run_queue_latency_monitor.sv]
// Run-queue latency monitor: top level with configuration registers.
// With the back end idle, a wakeup answers from the idle state, an unmatched
// switch after the task-store lookup, a matched switch after the lookup, the
// divide by 1000 (four 32x32 partial products), bucketing, a store read and the
// update. Results cannot stall. The back end holds one transaction at a time;
// a two-entry queue takes start while the back end works and the queue has room.
// Reset clears registers and runs a clearing pass over the task store.
`default_nettype none

module run_queue_latency_monitor
   import rqlm_pkg::*;
#(
   parameter int unsigned TASK_SLOTS  = 1024,
   parameter int unsigned GROUP_SLOTS = 256
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire logic                 req_func,
   input  wire logic [TASK_W-1:0]    req_task_id,
   input  wire logic [GROUP_W-1:0]   req_group_id,
   input  wire logic [TIME_W-1:0]    req_timestamp_ns,
   output      logic                 rsp_valid,
   output      logic                 rsp_matched,
   output      logic [TIME_W-1:0]    rsp_wait_ns,
   output      logic [US_W-1:0]      rsp_wait_us,
   output      logic [BUCKET_W-1:0]  rsp_bucket,
   output      logic [TIME_W-1:0]    rsp_bucket_count,
   output      logic                 rsp_tracked,
   output      logic                 rsp_slow,
   output      logic [TIME_W-1:0]    rsp_grp_switches,
   output      logic [TIME_W-1:0]    rsp_grp_total_ns,
   output      logic [TIME_W-1:0]    rsp_grp_max_ns,
   output      logic [TIME_W-1:0]    rsp_grp_slow_count,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIME_W-1:0]    csr_wdata
);

   logic [TIME_W-1:0] slow_threshold_ff, slow_threshold_in;
   logic [TIME_W-1:0] track_floor_ff, track_floor_in;
   item_type          req_item;
   head_type          head;
   logic              pop;
   logic              clearing;
   rsp_type           rsp;

   // configuration registers
   always_comb begin
      slow_threshold_in = slow_threshold_ff;
      track_floor_in    = track_floor_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SLOW_THRESHOLD: slow_threshold_in = csr_wdata;
            REG_TRACK_FLOOR:    track_floor_in    = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_threshold_ff <= SLOW_THRESHOLD_RST;
         track_floor_ff    <= TRACK_FLOOR_RST;
      end else begin
         slow_threshold_ff <= slow_threshold_in;
         track_floor_ff    <= track_floor_in;
      end
   end

   assign req_item.func         = func_type'(req_func);
   assign req_item.task_id      = req_task_id;
   assign req_item.group_id     = req_group_id;
   assign req_item.timestamp_ns = req_timestamp_ns;

   rqlm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .item_i     (req_item),
      .clearing_i (clearing),
      .pop_i      (pop),
      .head_o     (head),
      .busy       (busy)
   );

   rqlm_back #(
      .TASK_SLOTS  (TASK_SLOTS),
      .GROUP_SLOTS (GROUP_SLOTS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_i           (head),
      .slow_threshold_i (slow_threshold_ff),
      .track_floor_i    (track_floor_ff),
      .pop_o            (pop),
      .clearing_o       (clearing),
      .rsp_valid_o      (rsp_valid),
      .rsp_o            (rsp)
   );

   assign rsp_matched        = rsp.matched;
   assign rsp_wait_ns        = rsp.wait_ns;
   assign rsp_wait_us        = rsp.wait_us;
   assign rsp_bucket         = rsp.bucket;
   assign rsp_bucket_count   = rsp.bucket_count;
   assign rsp_tracked        = rsp.tracked;
   assign rsp_slow           = rsp.slow;
   assign rsp_grp_switches   = rsp.grp_switches;
   assign rsp_grp_total_ns   = rsp.grp_total_ns;
   assign rsp_grp_max_ns     = rsp.grp_max_ns;
   assign rsp_grp_slow_count = rsp.grp_slow_count;

endmodule

`default_nettype wire

[dv/run_queue_latency_monitor_checker.sv]
// checker for the run-queue latency monitor: wait prediction and result comparison
`default_nettype none

module run_queue_latency_monitor_checker
   import rqlm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic                 req_func,
   input  wire logic [TASK_W-1:0]    req_task_id,
   input  wire logic [GROUP_W-1:0]   req_group_id,
   input  wire logic [TIME_W-1:0]    req_timestamp_ns,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_matched,
   input  wire logic [TIME_W-1:0]    rsp_wait_ns,
   input  wire logic [US_W-1:0]      rsp_wait_us,
   input  wire logic [BUCKET_W-1:0]  rsp_bucket,
   input  wire logic [TIME_W-1:0]    rsp_bucket_count,
   input  wire logic                 rsp_tracked,
   input  wire logic                 rsp_slow,
   input  wire logic [TIME_W-1:0]    rsp_grp_switches,
   input  wire logic [TIME_W-1:0]    rsp_grp_total_ns,
   input  wire logic [TIME_W-1:0]    rsp_grp_max_ns,
   input  wire logic [TIME_W-1:0]    rsp_grp_slow_count,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIME_W-1:0]    csr_wdata,
   output int                        fail_count,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [TIME_W-1:0] slow_limit_us, floor_us;
   logic [TIME_W-1:0] wake_stamp [1024];
   bit                wake_armed [1024];
   logic [TIME_W-1:0] hist_count [HIST_DEPTH];
   grp_entry_type     grp_stats [256];
   rsp_type           expected_rsps [$];

   assign pending = expected_rsps.size();

   // predicted result of one transaction, updating the shadow state
   function automatic rsp_type predict_latency(item_type it);
      rsp_type r;
      logic [TIME_W-1:0] wns, wus, v;
      int b;
      r = '0;
      if (it.func == FUNC_WAKEUP) begin
         wake_stamp[it.task_id] = it.timestamp_ns;
         wake_armed[it.task_id] = 1'b1;
         return r;
      end
      if (!wake_armed[it.task_id]) return r;
      wake_armed[it.task_id] = 1'b0;
      wns = it.timestamp_ns - wake_stamp[it.task_id];
      wus = wns / 64'd1000;
      v = wus + 64'd1;
      b = 0;
      for (int i = 0; i < 64; i++) if (v[i]) b = i;
      if (v == 0) b = 0;
      hist_count[b] = hist_count[b] + 64'd1;
      r.matched = 1'b1;
      r.wait_ns = wns;
      r.wait_us = wus[US_W-1:0];
      r.bucket = BUCKET_W'(b);
      r.bucket_count = hist_count[b];
      r.slow = wus >= slow_limit_us;
      if (wus >= floor_us) begin
         grp_entry_type g;
         g = grp_stats[it.group_id];
         g.switches = g.switches + 64'd1;
         g.total_ns = g.total_ns + wns;
         if (r.slow) g.slow_count = g.slow_count + 64'd1;
         if (wns > g.max_ns) g.max_ns = wns;
         g.last_seen = it.timestamp_ns;
         grp_stats[it.group_id] = g;
         r.tracked = 1'b1;
         r.grp_switches = g.switches;
         r.grp_total_ns = g.total_ns;
         r.grp_max_ns = g.max_ns;
         r.grp_slow_count = g.slow_count;
      end
      return r;
   endfunction

   task automatic report_field(string name, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, got_v);
         fail_count++;
      end
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin
      if (reset) begin
         slow_limit_us <= SLOW_THRESHOLD_RST;
         floor_us <= TRACK_FLOOR_RST;
         for (int i = 0; i < 1024; i++) wake_armed[i] = 1'b0;
         for (int i = 0; i < HIST_DEPTH; i++) hist_count[i] = '0;
         for (int i = 0; i < 256; i++) grp_stats[i] = '0;
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_SLOW_THRESHOLD) slow_limit_us <= csr_wdata;
            else floor_us <= csr_wdata;
         end
         if (rsp_valid) begin
            rsp_type e;
            if (expected_rsps.size() == 0) begin
               $display("%0t mismatch: result with nothing expected", $realtime);
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               report_field("matched", TIME_W'(e.matched), TIME_W'(rsp_matched));
               report_field("wait_ns", e.wait_ns, rsp_wait_ns);
               report_field("wait_us", TIME_W'(e.wait_us), TIME_W'(rsp_wait_us));
               report_field("bucket", TIME_W'(e.bucket), TIME_W'(rsp_bucket));
               report_field("bucket_count", e.bucket_count, rsp_bucket_count);
               report_field("tracked", TIME_W'(e.tracked), TIME_W'(rsp_tracked));
               report_field("slow", TIME_W'(e.slow), TIME_W'(rsp_slow));
               report_field("grp_switches", e.grp_switches, rsp_grp_switches);
               report_field("grp_total_ns", e.grp_total_ns, rsp_grp_total_ns);
               report_field("grp_max_ns", e.grp_max_ns, rsp_grp_max_ns);
               report_field("grp_slow_count", e.grp_slow_count, rsp_grp_slow_count);
            end
         end
         if (start && !busy) begin
            item_type it;
            it.func = func_type'(req_func);
            it.task_id = req_task_id;
            it.group_id = req_group_id;
            it.timestamp_ns = req_timestamp_ns;
            expected_rsps.push_back(predict_latency(it));
         end
      end
   end
endmodule

`default_nettype wire

[dv/run_queue_latency_monitor_test.sv]
// testbench top for the run-queue latency monitor: stimulus and verdict
`default_nettype none

module run_queue_latency_monitor_test
   import rqlm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0, reset = 1'b1, start = 1'b0;
   logic busy;
   logic req_func = 1'b0;
   logic [TASK_W-1:0] req_task_id = '0;
   logic [GROUP_W-1:0] req_group_id = '0;
   logic [TIME_W-1:0] req_timestamp_ns = '0;
   logic rsp_valid, rsp_matched, rsp_tracked, rsp_slow;
   logic [TIME_W-1:0] rsp_wait_ns, rsp_bucket_count, rsp_grp_switches;
   logic [TIME_W-1:0] rsp_grp_total_ns, rsp_grp_max_ns, rsp_grp_slow_count;
   logic [US_W-1:0] rsp_wait_us;
   logic [BUCKET_W-1:0] rsp_bucket;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_SLOW_THRESHOLD;
   logic [TIME_W-1:0] csr_wdata = '0;
   int fail_count, pending;
   int idle_cycles = 0;
   logic [TIME_W-1:0] sim_now = 64'd1000000;

   localparam int WATCHDOG_LIMIT = 5000;

   run_queue_latency_monitor dut (.*);
   run_queue_latency_monitor_checker checker_u (.*);

   initial forever #4 clock = ~clock;

   // watchdog on cycles without an accepted transaction or a result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("run_queue_latency_monitor regression: fail");
         $finish;
      end
   end

   // start stays high into a back-to-back transaction and drops only for a gap
   task automatic send_event(func_type f, int t, int g, logic [TIME_W-1:0] ts, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_func <= f;
      req_task_id <= TASK_W'(t);
      req_group_id <= GROUP_W'(g);
      req_timestamp_ns <= ts;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [TIME_W-1:0] v);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // random sequence: mostly wakeup then switch pairs with a random wait
   task automatic random_phase(int n, bit gaps);
      int t, g;
      logic [TIME_W-1:0] w;
      for (int i = 0; i < n; i++) begin
         t = $urandom_range(0, 1023);
         g = $urandom_range(0, 255);
         case ($urandom_range(0, 4))
            0: w = {$urandom, $urandom};
            1: w = $urandom_range(0, 2000);
            default: w = 64'($urandom_range(0, 20000000)) << $urandom_range(0, 10);
         endcase
         if ($urandom_range(0, 9) < 8) begin
            send_event(FUNC_WAKEUP, t, g, sim_now, gaps);
            if ($urandom_range(0, 9) == 0) send_event(FUNC_WAKEUP, t, g, sim_now, gaps);
            sim_now = sim_now + w;
            send_event(FUNC_SWITCH, t, g % 8, sim_now, gaps);
         end else begin
            send_event(func_type'($urandom_range(0, 1)), t, g, {$urandom, $urandom}, gaps);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: unmatched switch, extremes, wrap-around, repeated wakeup
      send_event(FUNC_SWITCH, 5, 3, 64'd50, 1'b0);
      send_event(FUNC_WAKEUP, 0, 0, 64'd0, 1'b0);
      send_event(FUNC_SWITCH, 0, 0, 64'd999, 1'b0);
      send_event(FUNC_WAKEUP, 1023, 255, '1, 1'b0);
      send_event(FUNC_SWITCH, 1023, 255, 64'd5, 1'b0);
      send_event(FUNC_WAKEUP, 1, 255, 64'd0, 1'b0);
      send_event(FUNC_SWITCH, 1, 255, '1, 1'b0);
      send_event(FUNC_SWITCH, 1, 255, '1, 1'b0);
      send_event(FUNC_WAKEUP, 2, 0, 64'd10, 1'b0);
      send_event(FUNC_WAKEUP, 2, 0, 64'd100000, 1'b0);
      send_event(FUNC_SWITCH, 2, 170, 64'd200000, 1'b0);
      send_event(FUNC_WAKEUP, 3, 0, 64'd0, 1'b0);
      send_event(FUNC_SWITCH, 3, 170, 64'd6000000000, 1'b0);
      send_event(FUNC_WAKEUP, 682, 85, 64'h5555_5555_5555_5555, 1'b0);
      send_event(FUNC_SWITCH, 341, 85, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_event(FUNC_SWITCH, 682, 85, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      random_phase(200, 1'b1);
      write_reg(REG_SLOW_THRESHOLD, 64'd0);
      write_reg(REG_TRACK_FLOOR, 64'd0);
      random_phase(150, 1'b0);
      write_reg(REG_SLOW_THRESHOLD, '1);
      write_reg(REG_TRACK_FLOOR, '1);
      random_phase(100, 1'b1);
      write_reg(REG_SLOW_THRESHOLD, 64'd300);
      write_reg(REG_TRACK_FLOOR, 64'd20);
      random_phase(100, 1'b1);
      start <= 1'b0;
      // wait for the last results to drain
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0) $display("run_queue_latency_monitor regression: pass");
      else $display("run_queue_latency_monitor regression: fail");
      $finish;
   end
endmodule

`default_nettype wire

[filelist.f]
rtl/core/rqlm_pkg.sv
rtl/core/rqlm_front.sv
rtl/core/rqlm_div1000.sv
rtl/core/rqlm_back.sv
rtl/core/run_queue_latency_monitor.sv
dv/run_queue_latency_monitor_checker.sv
dv/run_queue_latency_monitor_test.sv
